FILE: hdl/hrk_pkg.sv
// ----------------------------------------------------------------------------
// hrk_pkg
// Shared constants and types for the Hermitian rank-k update engine.
// ----------------------------------------------------------------------------
package hrk_pkg;

    localparam int MAX_DIM = 64;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ELEM_W  = 64;
    localparam int DOT_W   = 48;
    localparam int ACC_W   = 56;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_C = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_READ_C  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_UPPER = 3'd0,
        REG_TRANS = 3'd1,
        REG_ORDER = 3'd2,
        REG_DEPTH = 3'd3,
        REG_ALPHA = 3'd4,
        REG_BETA  = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDATA,
        S_ELEM,
        S_AREAD,
        S_MUL,
        S_CREAD,
        S_FMUL,
        S_FADD,
        S_FRND,
        S_NEXT,
        S_DONE
    } state_t;

endpackage

FILE: hdl/hrk_ram.sv
// ----------------------------------------------------------------------------
// hrk_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hrk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/hermitian_rank_k_update.sv
// ----------------------------------------------------------------------------
// hermitian_rank_k_update
// Fixed-point HERK: C = alpha*A*A^H (A^H*A if trans) + beta*C on one triangle.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_stall and results leave on
// out_valid/out_stall. A write item (A or C element) gives no result. A read
// item returns its C element through the C store's read register and then the
// output register. A compute item walks the selected triangle of C element by
// element: one A read pair and five multiplier phases per inner step, then the
// real and imaginary finish (the real one alone on a diagonal element);
// skipped elements only advance the indices. An early exit compute goes
// straight to its done result.
// One item is worked on at a time; in_stall is high while busy or while a
// result still waits in the output register. A stalled result holds its value.
// Reset restores the register defaults and clears the saturation flag; the
// element stores are undefined until written and need no clearing pass.
// Write the configuration only while the block is idle.
// ----------------------------------------------------------------------------
module hermitian_rank_k_update
    import hrk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [IDX_W-1:0]   row_index,
    input  logic [IDX_W-1:0]   col_index,
    input  logic signed [31:0] real_value,
    input  logic signed [31:0] imag_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic [IDX_W-1:0]   out_row,
    output logic [IDX_W-1:0]   out_col,
    output logic signed [31:0] out_real,
    output logic signed [31:0] out_imag,
    output logic               saturated
);

    // configuration registers
    logic               upper_reg;
    logic               trans_reg;
    logic [6:0]         order_reg;
    logic [6:0]         depth_reg;
    logic signed [15:0] alpha_reg;
    logic signed [15:0] beta_reg;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, l_reg, l_next;
    logic [2:0]       ph_reg, ph_next;
    logic             fim_reg, fim_next;
    logic             flag_reg, flag_next;
    logic signed [ACC_W-1:0] dr_reg, dr_next, di_reg, di_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] res_re_reg, res_re_next;

    logic               out_valid_reg, out_valid_next;
    logic               kind_reg, kind_next;
    logic [IDX_W-1:0]   orow_reg, orow_next, ocol_reg, ocol_next;
    logic signed [31:0] ore_reg, ore_next, oim_reg, oim_next;

    // memory ports
    logic              a_wr_en, c_wr_en, a_rd_en, c_rd_en;
    logic [ADDR_W-1:0] a_wr_addr, c_wr_addr, u_addr, v_addr, c_rd_addr;
    logic [ELEM_W-1:0] a_wr_data, c_wr_data, u_data, v_data, c_data;

    // derived values
    logic [DIM_W-1:0] n_eff, k_eff;
    logic             out_free, accept, early_exit, use_c;
    logic             i_last, j_last, l_last, skip_elem;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] rnd_sum;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] dot_sel;
    logic signed [DOT_W-1:0] dot_sat;
    logic               dot_ovf;
    logic signed [31:0] c_sel;
    logic signed [63:0] fin_sum;
    logic signed [55:0] fin_rnd;
    logic signed [31:0] fin_sat;
    logic               fin_ovf;

    // clamp dimensions to the store size
    assign n_eff = (order_reg > 7'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(order_reg);
    assign k_eff = (depth_reg > 7'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(depth_reg);

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE) || !out_free;
    assign accept     = in_valid && !in_stall;
    assign use_c      = (beta_reg != 16'sd0);
    assign early_exit = (n_eff == '0)
        || (((alpha_reg == 16'sd0) || (k_eff == '0)) && (beta_reg == 16'sd256));

    assign i_last    = (DIM_W'(i_reg) == n_eff - DIM_W'(1));
    assign j_last    = (DIM_W'(j_reg) == n_eff - DIM_W'(1));
    assign l_last    = (DIM_W'(l_reg) == k_eff - DIM_W'(1));
    assign skip_elem = upper_reg ? (i_reg > j_reg) : (i_reg < j_reg);

    // A holds {real, imag}; u is the row/col i operand, v the j operand
    assign u_addr    = trans_reg ? {l_reg, i_reg} : {i_reg, l_reg};
    assign v_addr    = trans_reg ? {l_reg, j_reg} : {j_reg, l_reg};
    assign a_wr_en   = accept && (opcode == OP_WRITE_A);
    assign a_wr_addr = {row_index, col_index};
    assign a_wr_data = {real_value, imag_value};
    assign a_rd_en   = (state_reg == S_AREAD);

    hrk_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram_u (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (a_wr_addr),
        .wr_data (a_wr_data),
        .rd_en   (a_rd_en),
        .rd_addr (u_addr),
        .rd_data (u_data)
    );

    // second copy of A so both operands come out in the same cycle
    hrk_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram_v (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (a_wr_addr),
        .wr_data (a_wr_data),
        .rd_en   (a_rd_en),
        .rd_addr (v_addr),
        .rd_data (v_data)
    );

    hrk_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_c_ram (
        .clk     (clk),
        .wr_en   (c_wr_en),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_en   (c_rd_en),
        .rd_addr (c_rd_addr),
        .rd_data (c_data)
    );

    // shared multiplier operand select: ur*vr, um*vm, ur*vm, um*vr
    always_comb
    begin
        case (ph_reg[1:0])
            2'd0:    begin mul_a = u_data[63:32]; mul_b = v_data[63:32]; end
            2'd1:    begin mul_a = u_data[31:0];  mul_b = v_data[31:0];  end
            2'd2:    begin mul_a = u_data[63:32]; mul_b = v_data[31:0];  end
            default: begin mul_a = u_data[31:0];  mul_b = v_data[63:32]; end
        endcase
    end

    // round half up to Q16.16
    assign rnd_sum = prod_reg + 64'sd32768;
    assign term    = ACC_W'($signed(rnd_sum[63:16]));

    // finish: saturate dot to 48 bits, scale, add beta*c, round, saturate
    assign dot_sel = fim_reg ? di_reg : dr_reg;
    assign dot_ovf = (dot_sel[ACC_W-1:DOT_W-1] != '0) && (dot_sel[ACC_W-1:DOT_W-1] != '1);
    assign dot_sat = !dot_ovf ? dot_sel[DOT_W-1:0]
                   : (dot_sel[ACC_W-1] ? {1'b1, {(DOT_W-1){1'b0}}}
                                       : {1'b0, {(DOT_W-1){1'b1}}});
    assign c_sel   = fim_reg ? c_data[31:0] : c_data[63:32];
    assign fin_sum = acc_reg + 64'sd128;
    assign fin_rnd = fin_sum[63:8];
    assign fin_ovf = (fin_rnd[55:31] != '0) && (fin_rnd[55:31] != '1);
    assign fin_sat = !fin_ovf ? fin_rnd[31:0]
                   : (fin_rnd[55] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= 1'b1;
            trans_reg <= 1'b0;
            order_reg <= '0;
            depth_reg <= '0;
            alpha_reg <= 16'sd256;
            beta_reg  <= 16'sd256;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_UPPER: upper_reg <= cfg_wdata[0];
                REG_TRANS: trans_reg <= cfg_wdata[0];
                REG_ORDER: order_reg <= cfg_wdata[6:0];
                REG_DEPTH: depth_reg <= cfg_wdata[6:0];
                REG_ALPHA: alpha_reg <= cfg_wdata;
                REG_BETA:  beta_reg  <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            l_reg         <= '0;
            ph_reg        <= '0;
            fim_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            l_reg         <= l_next;
            ph_reg        <= ph_next;
            fim_reg       <= fim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg     <= dr_next;
        di_reg     <= di_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        res_re_reg <= res_re_next;
        kind_reg   <= kind_next;
        orow_reg   <= orow_next;
        ocol_reg   <= ocol_next;
        ore_reg    <= ore_next;
        oim_reg    <= oim_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        flag_next      = flag_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        l_next         = l_reg;
        ph_next        = ph_reg;
        fim_next       = fim_reg;
        dr_next        = dr_reg;
        di_next        = di_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        res_re_next    = res_re_reg;
        kind_next      = kind_reg;
        orow_next      = orow_reg;
        ocol_next      = ocol_reg;
        ore_next       = ore_reg;
        oim_next       = oim_reg;
        out_valid_next = out_valid_reg && out_stall;
        c_wr_en        = 1'b0;
        c_wr_addr      = {i_reg, j_reg};
        c_wr_data      = {res_re_reg, fin_sat};
        c_rd_en        = 1'b0;
        c_rd_addr      = {i_reg, j_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_WRITE_C:
                        begin
                            c_wr_en   = 1'b1;
                            c_wr_addr = {row_index, col_index};
                            c_wr_data = {real_value, imag_value};
                        end
                        OP_READ_C:
                        begin
                            c_rd_en    = 1'b1;
                            c_rd_addr  = {row_index, col_index};
                            orow_next  = row_index;
                            ocol_next  = col_index;
                            state_next = S_RDATA;
                        end
                        OP_COMPUTE:
                        begin
                            flag_next = 1'b0;
                            i_next    = '0;
                            j_next    = '0;
                            state_next = early_exit ? S_DONE : S_ELEM;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDATA:
            begin
                kind_next      = 1'b1;
                ore_next       = c_data[63:32];
                oim_next       = c_data[31:0];
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_ELEM:
            begin
                dr_next  = '0;
                di_next  = '0;
                l_next   = '0;
                fim_next = 1'b0;
                if (skip_elem)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = (k_eff == '0) ? S_CREAD : S_AREAD;
                end
            end
            S_AREAD:
            begin
                ph_next    = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // multiply in phases 0..3, fold the previous product in phases 1..4
                if (ph_reg != 3'd4)
                begin
                    prod_next = mul_a * mul_b;
                end
                case (ph_reg)
                    3'd1, 3'd2: dr_next = dr_reg + term;
                    3'd3:       di_next = trans_reg ? di_reg + term : di_reg - term;
                    3'd4:       di_next = trans_reg ? di_reg - term : di_reg + term;
                    default:    ;
                endcase
                ph_next = ph_reg + 3'd1;
                if (ph_reg == 3'd4)
                begin
                    if (l_last)
                    begin
                        state_next = S_CREAD;
                    end
                    else
                    begin
                        l_next     = l_reg + 1'b1;
                        state_next = S_AREAD;
                    end
                end
            end
            S_CREAD:
            begin
                c_rd_en    = 1'b1;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                if (dot_ovf)
                begin
                    flag_next = 1'b1;
                end
                acc_next   = 64'(alpha_reg * dot_sat);
                state_next = S_FADD;
            end
            S_FADD:
            begin
                if (use_c)
                begin
                    acc_next = acc_reg + 64'(beta_reg * c_sel);
                end
                state_next = S_FRND;
            end
            S_FRND:
            begin
                if (fin_ovf)
                begin
                    flag_next = 1'b1;
                end
                if (fim_reg)
                begin
                    c_wr_en    = 1'b1;
                    state_next = S_NEXT;
                end
                else if (i_reg == j_reg)
                begin
                    // diagonal: imaginary part forced to zero
                    c_wr_en    = 1'b1;
                    c_wr_data  = {fin_sat, 32'sd0};
                    state_next = S_NEXT;
                end
                else
                begin
                    res_re_next = fin_sat;
                    fim_next    = 1'b1;
                    state_next  = S_FMUL;
                end
            end
            S_NEXT:
            begin
                if (j_last)
                begin
                    j_next = '0;
                    if (i_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_ELEM;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_ELEM;
                end
            end
            S_DONE:
            begin
                kind_next      = 1'b0;
                orow_next      = '0;
                ocol_next      = '0;
                ore_next       = '0;
                oim_next       = '0;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign out_row     = orow_reg;
    assign out_col     = ocol_reg;
    assign out_real    = ore_reg;
    assign out_imag    = oim_reg;
    assign saturated   = flag_reg;

`ifndef SYNTH
    // no new item while the sequencer is busy
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item accepted while busy");

    // a stalled result is neither dropped nor changed
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(ore_reg)
            && $stable(oim_reg) && $stable(kind_reg)))
        else $error("pending result lost");

    // a result is loaded only into an empty output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RDATA) || (state_reg == S_DONE)) |-> !out_valid_reg)
        else $error("result overwrites a pending one");

    // the C store is written back only at the end of an element finish
    a_wb_state: assert property (@(posedge clk) disable iff (!rst_n)
        (c_wr_en && (state_reg != S_IDLE)) |-> (state_reg == S_FRND))
        else $error("unexpected C write-back");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-point HERK engine. A corner of both stores
// is filled first, then directed items cover the triangles, the transpose,
// the early exits, zero beta, scaling only and saturation. Random items follow
// in four phases of sender idling and receiver stalling. Every result is
// checked against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb;
    import hrk_pkg::*;

    localparam bit   KIND_DONE   = 1'b0;
    localparam bit   KIND_READ   = 1'b1;
    localparam int   CYCLE_LIMIT = 3000000;
    localparam int   FILL_DIM    = 6;
    localparam longint DOT_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DOT_LO    = -64'sh0000_8000_0000_0000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
    logic signed [31:0] real_value;
    logic signed [31:0] imag_value;
    logic               out_valid;
    logic               out_stall;
    logic               result_kind;
    logic [IDX_W-1:0]   out_row;
    logic [IDX_W-1:0]   out_col;
    logic signed [31:0] out_real;
    logic signed [31:0] out_imag;
    logic               saturated;

    hermitian_rank_k_update i_dut (.*);

    typedef struct {
        bit          kind;
        bit [5:0]    row;
        bit [5:0]    col;
        bit [31:0]   re;
        bit [31:0]   im;
        bit          sat;
    } herk_result_t;

    herk_result_t result_q[$];

    // Shadow copy of the block: stores, flag and registers
    int      a_re[DEPTH];
    int      a_im[DEPTH];
    int      c_re[DEPTH];
    int      c_im[DEPTH];
    bit      sat_flag;
    bit      sh_upper;
    bit      sh_trans;
    bit [6:0] sh_order;
    bit [6:0] sh_depth;
    shortint sh_alpha;
    shortint sh_beta;

    int      idle_pct;
    int      stall_pct;
    int      errors;
    int      cycles;
    int      computes_sent;
    int      reads_sent;
    int      sat_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[hermitian_rank_k_update] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    // Round half up to a shift of s bits; >>> on a signed value is floor
    function automatic longint round_half_up(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mul_fix(int a, int b);
        return round_half_up(longint'(a) * longint'(b), 16);
    endfunction

    function automatic int finish_elem(longint dot, longint cval, bit use_c);
        longint acc;
        longint r;
        if (dot > DOT_HI)
        begin
            dot = DOT_HI;
            sat_flag = 1'b1;
        end
        if (dot < DOT_LO)
        begin
            dot = DOT_LO;
            sat_flag = 1'b1;
        end
        acc = longint'(sh_alpha) * dot;
        if (use_c)
            acc += longint'(sh_beta) * cval;
        r = round_half_up(acc, 8);
        if (r > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
            sat_flag = 1'b1;
        end
        if (r < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
            sat_flag = 1'b1;
        end
        return int'(r);
    endfunction

    function automatic void herk_update();
        int     n;
        int     k;
        int     ci;
        int     ui;
        int     vi;
        longint dr;
        longint di;
        bit     use_c;
        n = (sh_order > MAX_DIM) ? MAX_DIM : sh_order;
        k = (sh_depth > MAX_DIM) ? MAX_DIM : sh_depth;
        use_c = (sh_beta != 0);
        sat_flag = 1'b0;
        // Early exit: nothing to add and C kept as is
        if (n == 0 || ((sh_alpha == 0 || k == 0) && sh_beta == 256))
            return;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                if (sh_upper ? (i > j) : (i < j))
                    continue;
                ci = i * MAX_DIM + j;
                dr = 0;
                di = 0;
                for (int l = 0; l < k; l++)
                begin
                    if (sh_trans)
                    begin
                        ui = l * MAX_DIM + i;
                        vi = l * MAX_DIM + j;
                    end
                    else
                    begin
                        ui = i * MAX_DIM + l;
                        vi = j * MAX_DIM + l;
                    end
                    dr += mul_fix(a_re[ui], a_re[vi]) + mul_fix(a_im[ui], a_im[vi]);
                    if (sh_trans)
                        di += mul_fix(a_re[ui], a_im[vi]) - mul_fix(a_im[ui], a_re[vi]);
                    else
                        di += mul_fix(a_im[ui], a_re[vi]) - mul_fix(a_re[ui], a_im[vi]);
                end
                c_re[ci] = finish_elem(dr, c_re[ci], use_c);
                if (i == j)
                    c_im[ci] = 0;
                else
                    c_im[ci] = finish_elem(di, c_im[ci], use_c);
            end
        end
    endfunction

    // Apply one accepted item to the shadow and queue what it returns
    function automatic void predict_item(opcode_t op, bit [5:0] r, bit [5:0] c,
                                         int vr, int vi);
        herk_result_t res;
        int idx;
        idx = r * MAX_DIM + c;
        case (op)
            OP_WRITE_A:
            begin
                a_re[idx] = vr;
                a_im[idx] = vi;
            end
            OP_WRITE_C:
            begin
                c_re[idx] = vr;
                c_im[idx] = vi;
            end
            OP_COMPUTE:
            begin
                herk_update();
                res = '{KIND_DONE, 6'd0, 6'd0, 32'd0, 32'd0, sat_flag};
                if (sat_flag)
                    sat_seen++;
                result_q.push_back(res);
            end
            default:
            begin
                res = '{KIND_READ, r, c, c_re[idx], c_im[idx], sat_flag};
                result_q.push_back(res);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- checker

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        herk_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
                report_mismatch("unexpected result, kind", result_kind, 0);
            else
            begin
                want = result_q.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", result_kind, want.kind);
                if (out_row !== want.row)
                    report_mismatch("out_row", out_row, want.row);
                if (out_col !== want.col)
                    report_mismatch("out_col", out_col, want.col);
                if (out_real !== want.re)
                    report_mismatch("out_real", out_real, want.re);
                if (out_imag !== want.im)
                    report_mismatch("out_imag", out_imag, want.im);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic hold_off();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drive one item, hold it until taken, then predict it
    task automatic send_item(opcode_t op, bit [5:0] r, bit [5:0] c, int vr, int vi);
        while ($urandom_range(99) < idle_pct)
            hold_off();
        in_valid   <= 1'b1;
        opcode     <= op;
        row_index  <= r;
        col_index  <= c;
        real_value <= vr;
        imag_value <= vi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(op, r, c, vr, vi);
        if (op == OP_COMPUTE)
            computes_sent++;
        if (op == OP_READ_C)
            reads_sent++;
    endtask

    // Drain every expected result, then let the block settle
    task automatic drain();
        hold_off();
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_UPPER: sh_upper = val[0];
            REG_TRANS: sh_trans = val[0];
            REG_ORDER: sh_order = val[6:0];
            REG_DEPTH: sh_depth = val[6:0];
            REG_ALPHA: sh_alpha = val;
            REG_BETA:  sh_beta  = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(bit upper, bit trans, int n, int k, shortint alpha,
                            shortint beta);
        write_reg(REG_UPPER, 16'(upper));
        write_reg(REG_TRANS, 16'(trans));
        write_reg(REG_ORDER, 16'(n));
        write_reg(REG_DEPTH, 16'(k));
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_BETA, beta);
    endtask

    // Mostly modest values so that saturation stays the exception
    function automatic int pick_value();
        case ($urandom_range(7))
            0:       return $urandom;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh8000_0000;
            default: return int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic shortint pick_gain();
        case ($urandom_range(5))
            0:       return 16'sd0;
            1:       return 16'sd256;
            2:       return 16'sh7FFF;
            3:       return 16'sh8000;
            default: return 16'(int'($urandom_range(1024)) - 512);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // Write the corner of both stores that computes and reads touch
    task automatic test_fill_stores();
        for (int r = 0; r < FILL_DIM; r++)
            for (int c = 0; c < FILL_DIM; c++)
            begin
                send_item(OP_WRITE_A, 6'(r), 6'(c), pick_value(), pick_value());
                send_item(OP_WRITE_C, 6'(r), 6'(c), pick_value(), pick_value());
            end
    endtask

    task automatic test_directed();
        // Reset defaults: n is zero, so compute is an early exit
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        send_item(OP_WRITE_C, 6'd63, 6'd63, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OP_READ_C, 6'd63, 6'd63, 0, 0);
        send_item(OP_WRITE_A, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OP_WRITE_A, 0, 1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        // Plain upper update, then read the diagonal and two off-diagonal entries
        set_mode(1'b1, 1'b0, 4, 3, 16'sd256, 16'sd256);
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        send_item(OP_READ_C, 0, 0, 0, 0);
        send_item(OP_READ_C, 1, 3, 0, 0);
        send_item(OP_READ_C, 3, 1, 0, 0);
        // Lower triangle, transposed
        set_mode(1'b0, 1'b1, 4, 3, 16'sd128, 16'sd64);
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        send_item(OP_READ_C, 3, 1, 0, 0);
        // Zero beta drops the old C
        write_reg(REG_BETA, 16'sd0);
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        send_item(OP_READ_C, 2, 2, 0, 0);
        // Zero alpha with unit beta, then zero k with unit beta: C unchanged
        set_mode(1'b1, 1'b0, 3, 2, 16'sd0, 16'sd256);
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        write_reg(REG_ALPHA, 16'sd256);
        write_reg(REG_DEPTH, 16'd0);
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        // Zero alpha with other beta only scales
        set_mode(1'b1, 1'b0, 3, 2, 16'sd0, -16'sd300);
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        send_item(OP_READ_C, 1, 1, 0, 0);
        // Gain extremes on full-scale entries force saturation
        set_mode(1'b1, 1'b0, 2, 2, 16'sh8000, 16'sh7FFF);
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        send_item(OP_READ_C, 0, 1, 0, 0);
        // Full filled corner, lower plain, then upper transposed
        set_mode(1'b0, 1'b0, FILL_DIM, FILL_DIM, 16'sd256, 16'sd256);
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        send_item(OP_READ_C, 5, 0, 0, 0);
        set_mode(1'b1, 1'b1, FILL_DIM, FILL_DIM, 16'sd16, 16'sd256);
        send_item(OP_COMPUTE, 0, 0, 0, 0);
        send_item(OP_READ_C, 0, 5, 0, 0);
    endtask

    task automatic test_random_phase(int idle, int stall);
        int pick;
        idle_pct  = idle;
        stall_pct = stall;
        for (int s = 0; s < 2; s++)
        begin
            set_mode(1'($urandom_range(1)), 1'($urandom_range(1)),
                     int'($urandom_range(FILL_DIM)), int'($urandom_range(FILL_DIM)),
                     pick_gain(), pick_gain());
            for (int t = 0; t < 6; t++)
            begin
                // Now and then wait for all results before going on
                if ($urandom_range(19) == 0)
                    drain();
                pick = $urandom_range(99);
                if (pick < 30)
                    send_item(OP_WRITE_A, 6'($urandom), 6'($urandom),
                              pick_value(), pick_value());
                else if (pick < 50)
                    send_item(OP_WRITE_C, 6'($urandom), 6'($urandom),
                              pick_value(), pick_value());
                else if (pick < 70)
                    send_item(OP_COMPUTE, 6'($urandom), 6'($urandom), $urandom, $urandom);
                else
                    send_item(OP_READ_C, 6'($urandom_range(FILL_DIM - 1)),
                              6'($urandom_range(FILL_DIM - 1)), 0, 0);
            end
        end
    endtask

    // ---------------------------------------------------------------- main

    initial
    begin
        rst_n      <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= '0;
        cfg_wdata  <= '0;
        in_valid   <= 1'b0;
        opcode     <= '0;
        row_index  <= '0;
        col_index  <= '0;
        real_value <= '0;
        imag_value <= '0;
        errors        = 0;
        computes_sent = 0;
        reads_sent    = 0;
        sat_seen      = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        sat_flag      = 1'b0;
        sh_upper      = 1'b1;
        sh_trans      = 1'b0;
        sh_order      = 0;
        sh_depth      = 0;
        sh_alpha      = 16'sd256;
        sh_beta       = 16'sd256;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_stores();
        test_directed();
        test_random_phase(0, 0);
        test_random_phase(66, 0);
        test_random_phase(0, 66);
        test_random_phase(36, 36);
        drain();
        repeat (20) @(posedge clk);

        $display("covered: store fill, both triangles, transpose, early exits, zero beta,");
        $display("  saturation; %0d computes (%0d saturating), %0d reads",
                 computes_sent, sat_seen, reads_sent);
        if (errors == 0)
            $display("[hermitian_rank_k_update] OK");
        else
            $display("[hermitian_rank_k_update] ERROR");
        $finish;
    end

endmodule
